// ===== hw/rtl/bavg_pkg.sv =====
// Shared types and constants for the 4x4 block averaging pipeline.
package bavg_pkg;

  localparam int DEF_MAX_BLOCK_COLS = 512;
  localparam int MAX_BLOCK_ROWS     = 512;
  localparam int NUM_CHAN           = 3;
  localparam int CFG_W              = 10;
  localparam int CFG_IDX_W          = 1;
  localparam int BC_W               = 10;
  localparam int BR_W               = 9;
  localparam int OUT_BC_W           = 9;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd160;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd120;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BLOCKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_BLOCKS = 1'b1;

  typedef logic [NUM_CHAN-1:0][7:0] sum_t;

  typedef struct packed {
    logic [7:0] chan_0;
    logic [7:0] chan_1;
    logic [7:0] chan_2;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]          mean_0;
    logic [7:0]          mean_1;
    logic [7:0]          mean_2;
    logic [OUT_BC_W-1:0] block_col;
    logic [BR_W-1:0]     block_row;
    logic                frame_end;
  } blk_out_t;

  // position information for the pixel at the head of the stream
  typedef struct packed {
    logic [BC_W-1:0] block_col;
    logic [BR_W-1:0] block_row;
    logic            first;
    logic            last;
    logic            frame_end;
  } blk_ctl_t;

endpackage

// ===== hw/rtl/block_average_4x4_top.sv =====
// Top level: 4x4 block mean of a 3-byte raster pixel stream.
// Path: a block's last pixel enters the sum stage, then its means the output register.
// Throughput: one pixel per cycle when no finished block waits on a stalled output;
// partial sums are read on accept, written by the sum stage, and forwarded to the next read.
// Reset: position counters clear, width_blocks 160, height_blocks 120;
// the partial sum memory is not cleared, as each block starts its sums from zero.
module block_average_4x4_top import bavg_pkg::*; #(
  parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output blk_out_t             out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  blk_ctl_t ctl;
  logic     acc_en;

  bavg_pos #(.MAX_BLOCK_COLS(MAX_BLOCK_COLS)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (acc_en),
    .ctl       (ctl)
  );

  bavg_accum #(.MAX_BLOCK_COLS(MAX_BLOCK_COLS)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .ctl       (ctl),
    .in_stall  (in_stall),
    .acc_en    (acc_en),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ===== hw/rtl/bavg_pos.sv =====
// Frame size registers and raster position counters.
module bavg_pos import bavg_pkg::*; #(
  parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 adv,
  output blk_ctl_t             ctl
);

  localparam int EFF_MAX = (MAX_BLOCK_COLS < 1023) ? MAX_BLOCK_COLS : 1023;
  localparam int COL_W   = $clog2(4 * EFF_MAX);
  localparam int ROW_W   = 11;

  logic [CFG_W-1:0] width_blocks_r;
  logic [CFG_W-1:0] height_blocks_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic [11:0]      lim_col, lim_row, row_inc;
  logic             end_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_blocks_r  <= WIDTH_RESET;
      height_blocks_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH_BLOCKS:  width_blocks_r  <= cfg_data;
        REG_HEIGHT_BLOCKS: height_blocks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero counts as one; clamp to the storage and row limits
  always_comb begin
    if (width_blocks_r == '0)
      eff_w = CFG_W'(1);
    else if (13'(width_blocks_r) > 13'(EFF_MAX))
      eff_w = CFG_W'(EFF_MAX);
    else
      eff_w = width_blocks_r;
    if (height_blocks_r == '0)
      eff_h = CFG_W'(1);
    else if (height_blocks_r > CFG_W'(MAX_BLOCK_ROWS))
      eff_h = CFG_W'(MAX_BLOCK_ROWS);
    else
      eff_h = height_blocks_r;
  end

  // last pixel column and row of the frame: four per block, minus one
  assign lim_col = {eff_w - CFG_W'(1), 2'b11};
  assign lim_row = {eff_h - CFG_W'(1), 2'b11};
  assign end_col = (12'(col_r) >= lim_col);

  always_comb begin
    col_nxt = end_col ? '0 : col_r + COL_W'(1);
    row_inc = end_col ? 12'(row_r) + 12'd1 : 12'(row_r);
    row_nxt = (row_inc >= {eff_h, 2'b00}) ? '0 : ROW_W'(row_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    ctl.block_col = BC_W'(col_r >> 2);
    ctl.block_row = BR_W'(row_r >> 2);
    ctl.first     = (col_r[1:0] == 2'b00) && (row_r[1:0] == 2'b00);
    ctl.last      = (col_r[1:0] == 2'b11) && (row_r[1:0] == 2'b11);
    ctl.frame_end = (12'(col_r) == lim_col) && (12'(row_r) == lim_row);
  end

endmodule

// ===== hw/rtl/bavg_accum.sv =====
// Partial sum memory with read-modify-write, forwarding and result register.
module bavg_accum import bavg_pkg::*; #(
  parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  pix_in_t  in_data,
  input  blk_ctl_t ctl,
  output logic     in_stall,
  output logic     acc_en,
  output logic     out_valid,
  output blk_out_t out_data,
  input  logic     out_stall
);

  localparam int ADDR_W = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;

  sum_t              mem [MAX_BLOCK_COLS];
  sum_t              rdata_r;
  sum_t              wr_data_r;
  sum_t              s1_px_r;
  blk_ctl_t          s1_ctl_r;
  logic              s1_valid_r;
  logic              s1_fwd_r;
  logic              out_valid_r;
  blk_out_t          out_data_r;
  logic [ADDR_W-1:0] rd_addr, s1_addr;
  sum_t              base, sum, px;
  logic              s1_go;

  assign rd_addr = ADDR_W'(ctl.block_col);
  assign s1_addr = ADDR_W'(s1_ctl_r.block_col);

  // hold the stage while a finished block cannot enter the output register
  assign s1_go    = s1_valid_r && !(s1_ctl_r.last && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign acc_en   = in_valid && !in_stall;

  assign px[0] = {4'd0, in_data.chan_0[7:4]};
  assign px[1] = {4'd0, in_data.chan_1[7:4]};
  assign px[2] = {4'd0, in_data.chan_2[7:4]};

  always_comb begin
    if (s1_ctl_r.first)
      base = '0;
    else if (s1_fwd_r)
      base = wr_data_r;
    else
      base = rdata_r;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum[c] = base[c] + s1_px_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en)
      rdata_r <= mem[rd_addr];
    if (s1_go) begin
      mem[s1_addr] <= sum;
      wr_data_r    <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      s1_ctl_r <= ctl;
      s1_px_r  <= px;
      // the write landing at this edge is missed by the memory read
      s1_fwd_r <= s1_go && (s1_addr == rd_addr);
    end
    if (s1_go && s1_ctl_r.last) begin
      out_data_r.mean_0    <= sum[0];
      out_data_r.mean_1    <= sum[1];
      out_data_r.mean_2    <= sum[2];
      out_data_r.block_col <= OUT_BC_W'(s1_ctl_r.block_col);
      out_data_r.block_row <= s1_ctl_r.block_row;
      out_data_r.frame_end <= s1_ctl_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_en)
        s1_valid_r <= 1'b1;
      else if (s1_go)
        s1_valid_r <= 1'b0;
      if (s1_go && s1_ctl_r.last)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> $stable(rdata_r))
    else $error("read data changed under a held stage");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_ctl_r.last) |=> out_valid_r)
    else $error("finished block did not reach the output register");
  a_stage_filled: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en |=> s1_valid_r)
    else $error("accepted transaction lost before the sum stage");
`endif

endmodule
